// File: hw/rtl/sprite_scanline_evaluator_macros.svh
// assertion macros shared by the sprite scanline evaluator rtl
`ifndef SPRITE_SCANLINE_EVALUATOR_MACROS_SVH
`define SPRITE_SCANLINE_EVALUATOR_MACROS_SVH

// condition holds at every clock edge outside reset
`define SSE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sse_pkg.sv
// shared types and constants of the sprite scanline evaluator
`default_nettype none

package sse_pkg;

	// sprite index carried on the store ports (byte address bits 7:2)
	localparam int SPRITE_IDX_W = 6;

	// scanlines per frame
	localparam logic [9:0] LINE_TOTAL = 10'd262;

	// sprite heights in lines
	localparam logic [8:0] HEIGHT_SHORT = 9'd8;
	localparam logic [8:0] HEIGHT_TALL  = 9'd16;

	// item operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_TALL_SPRITES    = 2'd0;
	localparam logic [1:0] CFG_SPRITES_ENABLED = 2'd1;
	localparam logic [1:0] CFG_SPRITE_TABLE    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// byte write into the attribute store
	typedef struct packed {
		logic                    en;
		logic [SPRITE_IDX_W-1:0] sprite;
		logic [1:0]              lane;
		logic [7:0]              data;
	} oam_wr_t;

	// one kept sprite waiting to be reported
	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  attr;
		logic [12:0] paddr;
	} sprite_hit_t;

endpackage

`default_nettype wire

// File: hw/rtl/sse_oam_store.sv
// attribute store: one 32-bit word per sprite with byte writes and per-byte valid bits
`default_nettype none

module sse_oam_store import sse_pkg::*; #(
	parameter int SPRITE_COUNT = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire oam_wr_t                 wr,
	input  wire logic                    rd_en,
	input  wire logic [SPRITE_IDX_W-1:0] rd_sprite,
	output logic      [31:0]             rd_data
);

	localparam int IDX_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

	logic [31:0] mem [SPRITE_COUNT];
	logic [3:0]  vld_q [SPRITE_COUNT];
	logic [31:0] data_s1;
	logic [3:0]  vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.sprite[IDX_W-1:0]][wr.lane*8 +: 8] <= wr.data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_sprite[IDX_W-1:0]];
		end
	end

	// bytes never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SPRITE_COUNT; i++) begin
				vld_q[i] <= '0;
			end
			vld_s1 <= '0;
		end else begin
			if (wr.en) begin
				vld_q[wr.sprite[IDX_W-1:0]][wr.lane] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_sprite[IDX_W-1:0]];
			end
		end
	end

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			rd_data[b*8 +: 8] = vld_s1[b] ? data_s1[b*8 +: 8] : 8'h00;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sprite_scanline_evaluator.sv
// top level of the sprite scanline evaluator
// usage:
//  item channel (item_valid / item_stall): a word is either a byte write into
//  the attribute store (operation = write) or an evaluation of the line after
//  current_line (operation = evaluate). writes give no result.
//  result channel (result_valid / result_stall): an evaluation gives one word per
//  kept sprite, last set on the final one, or a single empty word when nothing
//  is kept. sprite_count and overflow are the same on every word of a line.
//  config channel (cfg_valid / cfg_ready): always ready, writes one of three
//  one-bit registers; write only while the block is idle.
//  timing: with sprites enabled, an evaluation walks the store through its single
//  read port, one sprite a cycle, and stops early on overflow; then it gives one
//  result word per cycle while the result channel does not stall. the block goes
//  back to idle and takes the next item once the final word is in the output register.
//  a stalled result word holds; the block waits in its emit phase meanwhile.
//  reset: registers clear to zero and every byte of the store reads as zero
//  until written; no clearing pass, items are taken straight after reset.
`default_nettype none

`include "sprite_scanline_evaluator_macros.svh"

module sprite_scanline_evaluator import sse_pkg::*; #(
	parameter int SPRITE_COUNT = 64,
	parameter int LINE_SLOTS   = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        operation,
	input  wire logic [7:0]  oam_address,
	input  wire logic [7:0]  oam_data,
	input  wire logic [8:0]  current_line,
	// config channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic        cfg_data,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             found,
	output logic [2:0]       slot,
	output logic [7:0]       sprite_x,
	output logic [7:0]       sprite_attributes,
	output logic [12:0]      pattern_address,
	output logic             overflow,
	output logic [3:0]       sprite_count,
	output logic             last
);

	// scan counter holds the sprite count itself
	localparam int SCAN_W = $clog2(SPRITE_COUNT + 1);
	// kept-sprite count holds LINE_SLOTS itself
	localparam int CNT_W  = $clog2(LINE_SLOTS + 1);
	localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;

	localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(SPRITE_COUNT);
	localparam logic [CNT_W-1:0]  SLOTS_MAX = CNT_W'(LINE_SLOTS);
	localparam logic [6:0]        SPRITES   = 7'(SPRITE_COUNT);

	// control registers
	state_t state_q, state_d;
	logic   tall_q, enable_q, table_q;
	logic   [SCAN_W-1:0] scan_idx_q;
	logic   chk_s1;
	logic   [CNT_W-1:0]  count_q;
	logic   ovf_q;
	logic   [SLOT_W-1:0] emit_idx_q;
	logic   result_valid_q;

	// payload registers
	logic        [8:0] target_q;
	sprite_hit_t       hits_q [LINE_SLOTS];
	logic              found_q, last_q, overflow_q;
	logic        [2:0] slot_q;
	logic        [3:0] count_out_q;
	sprite_hit_t       hit_out_q;

	logic        item_acc, out_free, out_load, rd_en;
	logic        eval_acc;
	oam_wr_t     wr;
	logic [31:0] rd_data;

	assign item_acc = item_valid && !item_stall;
	assign eval_acc = item_acc && (operation == OP_EVAL);
	assign out_free = !result_valid_q || !result_stall;
	assign cfg_ready = 1'b1;

	// store writes, out-of-range sprites dropped
	always_comb begin
		wr.en     = item_acc && (operation == OP_WRITE) && ({1'b0, oam_address[7:2]} < SPRITES);
		wr.sprite = oam_address[7:2];
		wr.lane   = oam_address[1:0];
		wr.data   = oam_data;
	end

	sse_oam_store #(
		.SPRITE_COUNT (SPRITE_COUNT)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_en     (rd_en),
		.rd_sprite (SPRITE_IDX_W'(scan_idx_q)),
		.rd_data   (rd_data)
	);

	// target line, wrapped once since line + 1 stays below twice the frame
	logic [9:0] line_inc;
	logic [8:0] target_d;
	always_comb begin
		line_inc = {1'b0, current_line} + 10'd1;
		target_d = (line_inc >= LINE_TOTAL) ? 9'(line_inc - LINE_TOTAL) : line_inc[8:0];
	end

	// compare of the sprite read last cycle
	logic [7:0]  spr_y, spr_tile, spr_attr, spr_x;
	logic [8:0]  diff, height;
	logic        hit, keep, ovf_hit, scan_done;
	logic [3:0]  row, row_tall;
	logic [2:0]  row_short;
	sprite_hit_t hit_d;

	always_comb begin
		spr_y     = rd_data[7:0];
		spr_tile  = rd_data[15:8];
		spr_attr  = rd_data[23:16];
		spr_x     = rd_data[31:24];
		height    = tall_q ? HEIGHT_TALL : HEIGHT_SHORT;
		diff      = target_q - {1'b0, spr_y};
		hit       = (target_q >= {1'b0, spr_y}) && (diff < height);
		row       = diff[3:0];
		// vertical flip mirrors the row inside the sprite
		row_tall  = spr_attr[7] ? ~row : row;
		row_short = spr_attr[7] ? ~row[2:0] : row[2:0];
		hit_d.x    = spr_x;
		hit_d.attr = spr_attr;
		// tall sprites take the table from tile bit 0, rows 8..15 from the next tile
		hit_d.paddr = tall_q ? {spr_tile[0], spr_tile[7:1], row_tall[3], 1'b0, row_tall[2:0]}
		                     : {table_q, spr_tile, 1'b0, row_short};
		keep      = (state_q == ST_SCAN) && chk_s1 && hit && (count_q != SLOTS_MAX);
		ovf_hit   = (state_q == ST_SCAN) && chk_s1 && hit && (count_q == SLOTS_MAX);
		scan_done = ovf_hit || ((scan_idx_q == SCAN_END) && !chk_s1);
	end

	// emit bookkeeping: an empty line still gives one word
	logic [CNT_W-1:0] n_words, emit_cnt;
	logic             emit_last;
	assign n_words   = (count_q == '0) ? CNT_W'(1) : count_q;
	assign emit_cnt  = CNT_W'(emit_idx_q) + CNT_W'(1);
	assign emit_last = (emit_cnt == n_words);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (eval_acc) begin
					state_d = enable_q ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item_stall = 1'b1;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: item_stall = 1'b0;
			ST_SCAN: rd_en      = (scan_idx_q != SCAN_END);
			ST_EMIT: out_load   = out_free;
			default: item_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q   <= 1'b0;
			enable_q <= 1'b0;
			table_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TALL_SPRITES:    tall_q   <= cfg_data;
				CFG_SPRITES_ENABLED: enable_q <= cfg_data;
				CFG_SPRITE_TABLE:    table_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan and emit control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			chk_s1     <= 1'b0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			emit_idx_q <= '0;
		end else begin
			chk_s1 <= rd_en;
			if (eval_acc) begin
				scan_idx_q <= '0;
				count_q    <= '0;
				ovf_q      <= 1'b0;
				emit_idx_q <= '0;
			end else begin
				if (rd_en) begin
					scan_idx_q <= scan_idx_q + SCAN_W'(1);
				end
				if (keep) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (ovf_hit) begin
					ovf_q <= 1'b1;
				end
				if (out_load) begin
					emit_idx_q <= emit_idx_q + SLOT_W'(1);
				end
			end
		end
	end

	// payload: target line and the kept-sprite buffer
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			target_q <= target_d;
		end
		if (keep) begin
			hits_q[count_q[SLOT_W-1:0]] <= hit_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q     <= (count_q != '0);
			slot_q      <= 3'(emit_idx_q);
			hit_out_q   <= (count_q != '0) ? hits_q[emit_idx_q] : '0;
			overflow_q  <= ovf_q;
			count_out_q <= 4'(count_q);
			last_q      <= emit_last;
		end
	end

	assign result_valid      = result_valid_q;
	assign found             = found_q;
	assign slot              = slot_q;
	assign sprite_x          = hit_out_q.x;
	assign sprite_attributes = hit_out_q.attr;
	assign pattern_address   = hit_out_q.paddr;
	assign overflow          = overflow_q;
	assign sprite_count      = count_out_q;
	assign last              = last_q;

	// checks
	`SSE_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= SLOTS_MAX, "kept count above slot limit")
	`SSE_ASSERT_ALWAYS(a_ovf_full, clk, arst_n, !ovf_q || (count_q == SLOTS_MAX), "overflow with free slots")
	`SSE_ASSERT_NEXT(a_last_idle, clk, arst_n, out_load && emit_last, state_q == ST_IDLE, "not idle after final word")
	`SSE_ASSERT_ALWAYS(a_empty_word, clk, arst_n, !result_valid_q || found_q || (count_out_q == 4'd0), "empty word with nonzero count")

endmodule

`default_nettype wire
